>>> src/urwde_pkg.sv
package urwde_pkg;

	// Datagram framing
	localparam logic [7:0] SYNC_BYTE = 8'h05;
	localparam logic [7:0] WRITE_BIT = 8'h80;
	localparam logic [7:0] CRC_POLY  = 8'h07;
	localparam int unsigned DGRAM_LEN = 8;
	localparam int unsigned IDX_W     = $clog2(DGRAM_LEN);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DGRAM_LEN - 1);

	typedef logic [7:0] byte_t;

	// One byte into the CRC-8, LSB first, crc shifts left
	function automatic byte_t crc_feed(input byte_t crc_in, input byte_t data_in);
		byte_t crc;
		byte_t dat;
		crc = crc_in;
		dat = data_in;
		for (int j = 0; j < 8; j++) begin
			if (crc[7] ^ dat[0]) begin
				crc = {crc[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				crc = {crc[6:0], 1'b0};
			end
			dat = {1'b0, dat[7:1]};
		end
		return crc;
	endfunction

endpackage

>>> src/uart_register_write_datagram_encoder_core.sv
// An accepted request passes stages 1, 2 and 3 and loads the byte serializer once
// it is idle or its last byte is taken. One datagram byte per cycle while out_stall
// is low, set by the serializer; the three CRC stages take a new request every cycle
// unless stalled. Reset (arst_n low, asynchronous): all stage valids and the
// serializer valid and index clear; slave_address returns to 0.
module uart_register_write_datagram_encoder_core (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_data,
	// request channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [6:0]  register_address,
	input  logic [31:0] write_data,
	input  logic [2:0]  link_index,
	// byte channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  tx_byte,
	output logic        last_byte,
	output logic [2:0]  link_out
);
	import urwde_pkg::*;

	logic [1:0]        slave_address_q;

	logic              v_s1, v_s2, v_s3;
	logic [1:0]        slave_s1, slave_s2, slave_s3;
	logic [6:0]        reg_s1, reg_s2, reg_s3;
	logic [31:0]       data_s1, data_s2, data_s3;
	logic [2:0]        link_s1, link_s2, link_s3;
	byte_t             crc_s1, crc_s2, crc_s3;

	logic [8*DGRAM_LEN-1:0] ser_q;
	logic [IDX_W-1:0]  idx_q;
	logic              ser_v_q;
	logic [2:0]        link_q;

	logic              in_accept, out_accept, load_ser;
	logic              ready_s1, ready_s2, ready_s3;
	byte_t             crc_hdr;

	// Config register, always ready
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slave_address_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			slave_address_q <= cfg_data;
		end
	end

	// Pipeline flow control
	assign out_accept = ser_v_q && !out_stall;
	assign load_ser   = v_s3 && (!ser_v_q || (out_accept && idx_q == LAST_IDX));
	assign ready_s3   = !v_s3 || load_ser;
	assign ready_s2   = !v_s2 || ready_s3;
	assign ready_s1   = !v_s1 || ready_s2;
	assign in_stall   = !ready_s1;
	assign in_accept  = in_valid && !in_stall;

	// CRC over sync, slave address and register byte
	assign crc_hdr = crc_feed(crc_feed(crc_feed(8'h00, SYNC_BYTE),
		{6'b0, slave_address_q}), {1'b0, register_address} | WRITE_BIT);

	// Stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (ready_s1) v_s1 <= in_valid;
			if (ready_s2) v_s2 <= v_s1;
			if (ready_s3) v_s3 <= v_s2;
		end
	end

	// Stage 1: header CRC, capture request
	always_ff @(posedge clk) begin
		if (in_accept) begin
			slave_s1 <= slave_address_q;
			reg_s1   <= register_address;
			data_s1  <= write_data;
			link_s1  <= link_index;
			crc_s1   <= crc_hdr;
		end
	end

	// Stage 2: two upper data bytes
	always_ff @(posedge clk) begin
		if (v_s1 && ready_s2) begin
			slave_s2 <= slave_s1;
			reg_s2   <= reg_s1;
			data_s2  <= data_s1;
			link_s2  <= link_s1;
			crc_s2   <= crc_feed(crc_feed(crc_s1, data_s1[31:24]), data_s1[23:16]);
		end
	end

	// Stage 3: two lower data bytes, CRC complete
	always_ff @(posedge clk) begin
		if (v_s2 && ready_s3) begin
			slave_s3 <= slave_s2;
			reg_s3   <= reg_s2;
			data_s3  <= data_s2;
			link_s3  <= link_s2;
			crc_s3   <= crc_feed(crc_feed(crc_s2, data_s2[15:8]), data_s2[7:0]);
		end
	end

	// Byte serializer: control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ser_v_q <= 1'b0;
			idx_q   <= '0;
		end else if (load_ser) begin
			ser_v_q <= 1'b1;
			idx_q   <= '0;
		end else if (out_accept) begin
			if (idx_q == LAST_IDX) ser_v_q <= 1'b0;
			idx_q <= idx_q + 1'b1;
		end
	end

	// Byte serializer: data, shifts one byte per accepted output byte
	always_ff @(posedge clk) begin
		if (load_ser) begin
			ser_q  <= {SYNC_BYTE, {6'b0, slave_s3}, {1'b0, reg_s3} | WRITE_BIT,
				data_s3, crc_s3};
			link_q <= link_s3;
		end else if (out_accept) begin
			ser_q <= {ser_q[8*DGRAM_LEN-9:0], 8'h00};
		end
	end

	assign out_valid = ser_v_q;
	assign tx_byte   = ser_q[8*DGRAM_LEN-1 -: 8];
	assign last_byte = (idx_q == LAST_IDX);
	assign link_out  = link_q;

	// Accepted request lands in stage 1
	a_in_to_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> v_s1)
		else $error("accepted request missing from stage 1");

	// A datagram is never cut short
	a_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		out_accept && !last_byte |=> out_valid)
		else $error("datagram dropped before its last byte");

	// Every datagram opens with the sync byte
	a_sync_first: assert property (@(posedge clk) disable iff (!arst_n)
		load_ser |=> out_valid && tx_byte == SYNC_BYTE && !last_byte)
		else $error("datagram does not start with sync");

	// Blocked stage 3 holds its CRC
	a_s3_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && !ready_s3 |=> v_s3 && $stable(crc_s3))
		else $error("stage 3 lost its item under stall");

endmodule
